>>> rtl/core/jd2cal_pkg.sv
// jd2cal_pkg: widths, span limits, fixed-point reciprocals and small date tables
// for the julian day to calendar date converter; no dependencies
package jd2cal_pkg;

  localparam int JD_W    = 22;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int DOY_W   = 9;

  // day counted from 1 nov 1 bc
  localparam int U_W = 20;
  // 100*u - 12210, scaled day count
  localparam int V_W = 27;
  localparam int P100_W = 29;
  // days from the start of a march based year, always below 512
  localparam int W_W = 9;
  localparam int A_W = 20;

  localparam logic [JD_W-1:0] JD_SPAN_LO = 22'd2415386;
  localparam logic [JD_W-1:0] JD_SPAN_HI = 22'd2488128;
  localparam logic [JD_W-1:0] JD_BASE    = 22'd1720982;
  // 100*base + 12210
  localparam logic [P100_W-1:0] V_OFS    = 29'd172110410;

  // ceil(2^43 / 36525), exact floor for v below 2^27
  localparam int YR_RECIP_W = 28;
  localparam int YR_SHIFT   = 43;
  localparam logic [YR_RECIP_W-1:0] YR_RECIP = 28'd240823903;

  // ceil(2^28 * 10000 / 306001), exact floor for w below 512
  localparam int MO_RECIP_W = 24;
  localparam int MO_SHIFT   = 28;
  localparam logic [MO_RECIP_W-1:0] MO_RECIP = 24'd8772372;

  localparam logic [MONTH_W-1:0] MO_JAN_NEXT = 4'd14;
  localparam logic [MONTH_W-1:0] MO_FEB_NEXT = 4'd15;
  localparam logic [MONTH_W-1:0] MO_FEB      = 4'd2;
  localparam logic [MONTH_W-1:0] MO_DEC      = 4'd12;
  localparam logic [YEAR_W-1:0]  YR_CENT_LO  = 12'd1900;
  localparam logic [YEAR_W-1:0]  YR_CENT_HI  = 12'd2100;

  // floor(30.6001 * m)
  function automatic logic [W_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [W_W-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  // days before month 1..12 in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/jd2cal_if.sv
// jd2cal_in_if and jd2cal_out_if: valid/ready channels for julian day words
// and calendar date words; depends on jd2cal_pkg
interface jd2cal_in_if;
  logic                          valid;
  logic                          ready;
  logic [jd2cal_pkg::JD_W-1:0]   julian_day;

  modport source (output valid, output julian_day, input ready);
  modport sink   (input valid, input julian_day, output ready);
endinterface

interface jd2cal_out_if;
  logic                            valid;
  logic                            ready;
  logic [jd2cal_pkg::YEAR_W-1:0]   year;
  logic [jd2cal_pkg::MONTH_W-1:0]  month;
  logic [jd2cal_pkg::DOM_W-1:0]    day_of_month;
  logic [jd2cal_pkg::DOY_W-1:0]    day_of_year;
  logic                            out_of_span;

  modport source (output valid, output year, output month, output day_of_month,
                  output day_of_year, output out_of_span, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input day_of_year, input out_of_span, output ready);
endinterface

>>> rtl/core/julian_day_to_calendar_date_top.sv
// julian_day_to_calendar_date_top: six stage pipeline from julian day number to
// gregorian date; depends on jd2cal_pkg, jd2cal_in_if and jd2cal_out_if
//
// Takes one julian day word per cycle while ready is high and returns its date word,
// one result per input, in order. The stage count is set by the two reciprocal
// multiplies (years and months), each followed by a register, with the scaling,
// month table lookup and day of year sum in stages of their own. Each stage keeps
// its own valid bit and holds only when the stage after it is full and stalled,
// so the input keeps being taken while a finished date waits, until every stage is full.
// Days outside 1901-01-01 to 2100-02-28 give out_of_span with zero date fields.
module julian_day_to_calendar_date_top (
  input  logic              clk,
  input  logic              rst,
  jd2cal_in_if.sink         jd,
  jd2cal_out_if.source      date
);
  import jd2cal_pkg::*;

  localparam int STAGES = 6;
  localparam int YP_W = V_W + YR_RECIP_W;
  localparam int MP_W = W_W + MO_RECIP_W;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   adv;

  // stage 1
  logic [U_W-1:0]  s1_u;
  logic [V_W-1:0]  s1_v;
  logic            s1_oos;
  // stage 2
  logic [YP_W-1:0] s2_prod;
  logic [U_W-1:0]  s2_u;
  logic            s2_oos;
  // stage 3
  logic [YEAR_W-1:0] s3_years;
  logic [W_W-1:0]    s3_w;
  logic              s3_oos;
  // stage 4
  logic [MP_W-1:0]   s4_prod;
  logic [YEAR_W-1:0] s4_years;
  logic [W_W-1:0]    s4_w;
  logic              s4_oos;
  // stage 5
  logic [YEAR_W-1:0]  s5_year;
  logic [MONTH_W-1:0] s5_month;
  logic [DOM_W-1:0]   s5_day;
  logic               s5_oos;
  // stage 6
  logic [YEAR_W-1:0]  s6_year;
  logic [MONTH_W-1:0] s6_month;
  logic [DOM_W-1:0]   s6_day;
  logic [DOY_W-1:0]   s6_doy;
  logic               s6_oos;

  logic [P100_W-1:0]  p100;
  logic [YEAR_W-1:0]  years_c;
  logic [A_W-1:0]     a_c;
  logic [MONTH_W-1:0] months_c;
  logic [W_W-1:0]     dom_c;
  logic [MONTH_W-1:0] month_next;
  logic [YEAR_W-1:0]  year_next;
  logic               leap;
  logic [DOY_W-1:0]   doy_next;

  // per stage flow control
  always_comb begin
    adv[STAGES] = date.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign jd.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= jd.valid;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // datapath
  always_comb begin
    p100 = P100_W'(jd.julian_day) * P100_W'(100);

    years_c = s2_prod[YP_W-1 -: YEAR_W];
    a_c = A_W'(s2_prod[YP_W-1 -: YEAR_W]) * A_W'(365)
        + A_W'(s2_prod[YP_W-1 -: YEAR_W] >> 2);

    months_c = s4_prod[MO_SHIFT +: MONTH_W];
    dom_c = s4_w - month_offset(s4_prod[MO_SHIFT +: MONTH_W]);
    if (months_c == MO_JAN_NEXT || months_c == MO_FEB_NEXT) begin
      month_next = months_c - 4'd13;
      year_next  = s4_years + 12'd1;
    end else begin
      month_next = months_c - 4'd1;
      year_next  = s4_years;
    end

    leap = (s5_year[1:0] == 2'b00) && (s5_year != YR_CENT_LO) && (s5_year != YR_CENT_HI);
    doy_next = DOY_W'(s5_day) + days_before(s5_month);
    if (leap && s5_month > MO_FEB && s5_month <= MO_DEC) begin
      doy_next = doy_next + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_u   <= U_W'(jd.julian_day - JD_BASE);
      s1_v   <= V_W'(p100 - V_OFS);
      s1_oos <= (jd.julian_day < JD_SPAN_LO) || (jd.julian_day > JD_SPAN_HI);
    end
    if (adv[1]) begin
      s2_prod <= YP_W'(s1_v) * YP_W'(YR_RECIP);
      s2_u    <= s1_u;
      s2_oos  <= s1_oos;
    end
    if (adv[2]) begin
      s3_years <= years_c;
      s3_w     <= W_W'(s2_u - U_W'(a_c));
      s3_oos   <= s2_oos;
    end
    if (adv[3]) begin
      s4_prod  <= MP_W'(s3_w) * MP_W'(MO_RECIP);
      s4_years <= s3_years;
      s4_w     <= s3_w;
      s4_oos   <= s3_oos;
    end
    if (adv[4]) begin
      s5_year  <= year_next;
      s5_month <= month_next;
      s5_day   <= DOM_W'(dom_c);
      s5_oos   <= s4_oos;
    end
    if (adv[5]) begin
      s6_year  <= s5_oos ? '0 : s5_year;
      s6_month <= s5_oos ? '0 : s5_month;
      s6_day   <= s5_oos ? '0 : s5_day;
      s6_doy   <= s5_oos ? '0 : doy_next;
      s6_oos   <= s5_oos;
    end
  end

  assign date.valid        = vld[STAGES-1];
  assign date.year         = s6_year;
  assign date.month        = s6_month;
  assign date.day_of_month = s6_day;
  assign date.day_of_year  = s6_doy;
  assign date.out_of_span  = s6_oos;

  // out of span words carry an all zero date
  a_oos_zero: assert property (@(posedge clk) disable iff (rst)
    date.valid && date.out_of_span |->
      date.year == '0 && date.month == '0 && date.day_of_month == '0 &&
      date.day_of_year == '0)
    else $error("out of span word with nonzero date");

  // an in span date is a real calendar date
  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    date.valid && !date.out_of_span |->
      date.month >= 4'd1 && date.month <= MO_DEC && date.day_of_month != '0 &&
      date.day_of_year != '0)
    else $error("in span word with impossible date");

  // input is held off only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !jd.ready |-> (&vld) && !date.ready)
    else $error("input stalled with a free stage");

endmodule

>>> tb/tb_julian_day_to_calendar_date_top.sv
// tb_julian_day_to_calendar_date_top: directed table and random julian day words through
// the date converter, with random stalls on both channels, checked against an in-bench
// date calculation; depends on jd2cal_pkg, jd2cal_in_if, jd2cal_out_if and the rtl top
module tb_julian_day_to_calendar_date_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jd2cal_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   day_of_month;
    logic [DOY_W-1:0]   day_of_year;
    logic               out_of_span;
  } cal_date_t;

  typedef struct packed {
    logic [JD_W-1:0] jd;
    logic            known;
    cal_date_t       date;
  } jd_row_t;

  localparam int unsigned RANDOM_WORDS   = 1030;
  localparam int unsigned CALM_WORDS     = 120;
  localparam int unsigned DRAIN_AT       = 500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 12;

  localparam cal_date_t NO_DATE  = '0;
  localparam cal_date_t OFF_SPAN = '{12'd0, 4'd0, 5'd0, 9'd0, 1'b1};

  localparam int unsigned CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                            304, 334};

  // span edges, leap days, year ends and bit patterns
  localparam jd_row_t DATE_TABLE [25] = '{
    '{22'd0,        1'b1, OFF_SPAN},
    '{22'h3FFFFF,   1'b1, OFF_SPAN},
    '{22'h200000,   1'b1, OFF_SPAN},
    '{22'd1720982,  1'b1, OFF_SPAN},
    '{22'd2415385,  1'b1, OFF_SPAN},
    '{22'd2415386,  1'b1, '{12'd1901, 4'd1, 5'd1, 9'd1, 1'b0}},
    '{22'd2415387,  1'b0, NO_DATE},
    '{22'd2415445,  1'b0, NO_DATE},
    '{22'd2416540,  1'b0, NO_DATE},
    '{22'd2416541,  1'b0, NO_DATE},
    '{22'd2416846,  1'b0, NO_DATE},
    '{22'd2451544,  1'b0, NO_DATE},
    '{22'd2451545,  1'b0, NO_DATE},
    '{22'd2451604,  1'b0, NO_DATE},
    '{22'd2451605,  1'b0, NO_DATE},
    '{22'd2451910,  1'b0, NO_DATE},
    '{22'd2488069,  1'b0, NO_DATE},
    '{22'd2488070,  1'b0, NO_DATE},
    '{22'd2488127,  1'b0, NO_DATE},
    '{22'd2488128,  1'b1, '{12'd2100, 4'd2, 5'd28, 9'd59, 1'b0}},
    '{22'd2488129,  1'b1, OFF_SPAN},
    '{22'h155555,   1'b1, OFF_SPAN},
    '{22'h2AAAAA,   1'b1, OFF_SPAN},
    '{22'd2449000,  1'b0, NO_DATE},
    '{22'd2437000,  1'b0, NO_DATE}
  };

  logic clk = 1'b0;
  logic rst;

  jd2cal_in_if  jd_if ();
  jd2cal_out_if date_if ();

  julian_day_to_calendar_date_top dut (
    .clk  (clk),
    .rst  (rst),
    .jd   (jd_if),
    .date (date_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cal_date_t   pending_dates [$];
  logic        use_known;
  cal_date_t   known_date;
  logic        calm;
  int unsigned tx_mode;
  int unsigned rx_mode;
  int unsigned rx_hold;
  int unsigned rx_count;
  int unsigned stall_cycles;
  int unsigned dates_seen;
  int unsigned mismatch_count;

  function automatic bit is_leap_year(input longint unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic cal_date_t convert_jd(input logic [JD_W-1:0] jd_in);
    cal_date_t r;
    longint unsigned u, yrs, a, mos, b, dom, yr, mo, doy;
    r = '0;
    if (jd_in < JD_SPAN_LO || jd_in > JD_SPAN_HI) begin
      r.out_of_span = 1'b1;
      return r;
    end
    u   = 64'(jd_in) - 64'(JD_BASE);
    yrs = (100 * u - 12210) / 36525;
    a   = (36525 * yrs) / 100;
    mos = (10000 * (u - a)) / 306001;
    b   = (306001 * mos) / 10000;
    dom = u - a - b;
    if (mos == 14 || mos == 15) begin
      mo = mos - 13;
      yr = yrs + 1;
    end else begin
      mo = mos - 1;
      yr = yrs;
    end
    doy = dom;
    if (mo >= 1 && mo <= 12) begin
      doy += 64'(CUM_DAYS[mo - 1]);
      if (mo > 2 && is_leap_year(yr)) doy += 1;
    end
    r.year         = yr[YEAR_W-1:0];
    r.month        = mo[MONTH_W-1:0];
    r.day_of_month = dom[DOM_W-1:0];
    r.day_of_year  = doy[DOY_W-1:0];
    return r;
  endfunction

  // mostly in span, then calendar boundaries, span edges and raw noise
  function automatic logic [JD_W-1:0] pick_jd();
    int unsigned sel, yr_ofs, day_ofs;
    sel = $urandom_range(0, 99);
    if (sel < 62) return JD_W'($urandom_range(32'(JD_SPAN_HI), 32'(JD_SPAN_LO)));
    if (sel < 80) begin
      yr_ofs = $urandom_range(0, 199);
      case ($urandom_range(0, 2))
        0: begin
          day_ofs = $urandom_range(0, 2);
        end
        1: begin
          day_ofs = $urandom_range(57, 62);
        end
        default: begin
          day_ofs = $urandom_range(363, 367);
        end
      endcase
      return JD_W'(32'(JD_SPAN_LO) + 365 * yr_ofs + yr_ofs / 4 + day_ofs - 1);
    end
    if (sel < 88) begin
      if ($urandom_range(0, 1) == 0)
        return JD_W'(32'(JD_SPAN_LO) - 4 + $urandom_range(0, 8));
      return JD_W'(32'(JD_SPAN_HI) - 4 + $urandom_range(0, 8));
    end
    return JD_W'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: date word %0d: %s got %0d want %0d", $time, dates_seen, what, got,
             want);
    mismatch_count++;
  endtask

  task automatic send_word(input logic [JD_W-1:0] jd_val, input logic known,
                           input cal_date_t date_val);
    if (!calm && tx_mode != 0 && $urandom_range(0, (tx_mode == 1) ? 15 : 3) == 0) begin
      jd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    jd_if.valid      <= 1'b1;
    jd_if.julian_day <= jd_val;
    use_known        <= known;
    known_date       <= date_val;
    @(posedge clk);
    while (!jd_if.ready) @(posedge clk);
  endtask

  // receiver stalls in bursts, with quiet stretches
  always @(posedge clk) begin
    if (rx_count % 150 == 0) rx_mode = $urandom_range(0, 2);
    rx_count++;
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (!calm && rx_mode != 0 &&
                 $urandom_range(0, (rx_mode == 1) ? 19 : 4) == 0) begin
      rx_hold = $urandom_range(1, 14);
    end
    date_if.ready <= (rx_hold == 0);
  end

  always @(posedge clk) begin
    cal_date_t want;
    logic      moved;
    moved = 1'b0;
    if (jd_if.valid && jd_if.ready) begin
      moved = 1'b1;
      pending_dates.push_back(use_known ? known_date : convert_jd(jd_if.julian_day));
    end
    if (date_if.valid && date_if.ready) begin
      moved = 1'b1;
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected word, out_of_span", 32'(date_if.out_of_span), 0);
      end else begin
        want = pending_dates.pop_front();
        if (date_if.year !== want.year)
          report_mismatch("year", 32'(date_if.year), 32'(want.year));
        if (date_if.month !== want.month)
          report_mismatch("month", 32'(date_if.month), 32'(want.month));
        if (date_if.day_of_month !== want.day_of_month)
          report_mismatch("day_of_month", 32'(date_if.day_of_month),
                          32'(want.day_of_month));
        if (date_if.day_of_year !== want.day_of_year)
          report_mismatch("day_of_year", 32'(date_if.day_of_year),
                          32'(want.day_of_year));
        if (date_if.out_of_span !== want.out_of_span)
          report_mismatch("out_of_span", 32'(date_if.out_of_span),
                          32'(want.out_of_span));
      end
      dates_seen++;
    end
    if (moved || rst) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, stall_cycles);
        $display("tb_julian_day_to_calendar_date_top: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    rst              = 1'b1;
    jd_if.valid      = 1'b0;
    jd_if.julian_day = '0;
    date_if.ready    = 1'b0;
    use_known        = 1'b0;
    known_date       = '0;
    calm             = 1'b0;
    tx_mode          = 0;
    rx_mode          = 0;
    rx_hold          = 0;
    rx_count         = 0;
    stall_cycles     = 0;
    dates_seen       = 0;
    mismatch_count   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DATE_TABLE[i]) send_word(DATE_TABLE[i].jd, DATE_TABLE[i].known, DATE_TABLE[i].date);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) tx_mode = $urandom_range(0, 2);
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if (n == DRAIN_AT) begin
        jd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0) @(posedge clk);
      end
      send_word(pick_jd(), 1'b0, NO_DATE);
    end
    jd_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_dates.size() != 0)
      report_mismatch("date words never returned", pending_dates.size(), 0);

    if (mismatch_count == 0) begin
      $display("tb_julian_day_to_calendar_date_top: clean");
    end else begin
      $display("tb_julian_day_to_calendar_date_top: errors");
    end
    $finish;
  end

endmodule
